// ===== sv/bcc_pkg.sv =====
// Shared types, fixed-point constants and helper functions of the balance cascade controller.
`timescale 1ns / 1ps

package bcc_pkg;

  // Internal fixed point: signed Q(32-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS   = 20;
  localparam int Q30_SHIFT   = 30 - FRAC_BITS;
  localparam int Q12_SHIFT   = FRAC_BITS - 12;
  localparam int Q15_SHIFT   = FRAC_BITS - 15;
  localparam int ATAN_LEN    = 24;
  localparam int MAC_TERMS   = 5;

  localparam logic signed [63:0] PI_K     = 64'sd3373259426 >>> Q30_SHIFT;
  // Gyro and wheel scales stay in Q30; the product is shifted down afterwards
  localparam logic signed [63:0] GYRO_K   = 64'sd11713;
  localparam logic signed [63:0] WHEEL_K  = 64'sd3162484;
  localparam logic signed [63:0] LIE_HI_K = 64'sd1825361101 >>> Q30_SHIFT;
  localparam logic signed [63:0] LIE_LO_K = 64'sd1610612736 >>> Q30_SHIFT;
  localparam logic signed [63:0] OVER_K   = 64'sd1020054733 >>> Q30_SHIFT;
  localparam logic signed [63:0] ONE_K    = 64'sd1 <<< FRAC_BITS;

  // Inner loop coefficients, Q16
  localparam logic signed [23:0] C_D0 = 24'sd102826;
  localparam logic signed [23:0] C_D1 = -24'sd37323;
  localparam logic signed [23:0] C_E0 = -24'sd169673;
  localparam logic signed [23:0] C_E1 = 24'sd301597;
  localparam logic signed [23:0] C_E2 = -24'sd133497;
  // Outer loop coefficients, Q16
  localparam logic signed [23:0] C_R0 = 24'sd91554;
  localparam logic signed [23:0] C_R1 = -24'sd26031;
  localparam logic signed [23:0] C_P0 = 24'sd8081;
  localparam logic signed [23:0] C_P1 = -24'sd15912;
  localparam logic signed [23:0] C_P2 = 24'sd7832;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  typedef enum logic [1:0] {
    MODE_IMU  = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_BTN  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_IMU,
    REQ_ENC,
    REQ_BTN,
    REQ_STATUS
  } req_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FELL  = 2'd1,
    FAULT_STALL = 2'd2,
    FAULT_RSVD  = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    CFG_BODY_TRIM      = 3'd0,
    CFG_START_RANGE    = 3'd1,
    CFG_TIP_LIMIT      = 3'd2,
    CFG_STEER_K        = 3'd3,
    CFG_OVERLOAD_LIMIT = 3'd4,
    CFG_PICKUP_LIMIT   = 3'd5,
    CFG_FILTER_ALPHA   = 3'd6,
    CFG_INNER_GAIN     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_rate;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               shutting_down;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               motors_enabled;
    logic               armed;
    logic [1:0]         fault;
    logic               zero_encoders;
    logic signed [15:0] body_angle;
  } out_item_t;

  typedef struct packed {
    req_kind_e          kind;
    logic               sd;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro;
    logic signed [31:0] left;
    logic signed [31:0] right;
  } req_t;

  typedef struct packed {
    logic signed [15:0] body_trim;
    logic [14:0]        start_range;
    logic [14:0]        tip_limit;
    logic [14:0]        steer_k;
    logic [9:0]         overload_limit;
    logic [9:0]         pickup_limit;
    logic [15:0]        filter_alpha;
    logic [15:0]        inner_gain;
  } cfg_t;

  function automatic logic signed [31:0] atan_k(input logic [4:0] idx);
    logic [31:0] v;
    v = 32'd0;
    if (idx < 5'(ATAN_LEN)) v = ATAN_Q30[idx] >> Q30_SHIFT;
    return $signed(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== sv/bcc_ifs.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface bcc_in_if;
  import bcc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcc_out_if;
  import bcc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bcc_front.sv =====
// Front end: accepts input requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module bcc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bcc_in_if.sink        in_i,
  output bcc_pkg::req_t req_o,
  output logic          req_valid_o,
  input  logic          req_pop_i
);
  import bcc_pkg::*;

  localparam int DEPTH = 2;

  req_t       mem_q [DEPTH];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       cls;
  logic       push;

  // Classify the request by mode
  always_comb begin
    cls.sd      = in_i.data.shutting_down;
    cls.accel_y = in_i.data.accel_y;
    cls.accel_z = in_i.data.accel_z;
    cls.gyro    = in_i.data.gyro_rate;
    cls.left    = in_i.data.left_count;
    cls.right   = in_i.data.right_count;
    unique case (mode_e'(in_i.data.mode))
      MODE_IMU: cls.kind = REQ_IMU;
      MODE_ENC: cls.kind = in_i.data.shutting_down ? REQ_STATUS : REQ_ENC;
      MODE_BTN: cls.kind = in_i.data.shutting_down ? REQ_STATUS : REQ_BTN;
      default:  cls.kind = REQ_STATUS;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'(DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = mem_q[rd_q];

  // Advance queue pointers
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = req_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(req_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed request
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

endmodule

// ===== sv/bcc_back.sv =====
// Back end: CORDIC, filters, IIR loops and arming logic on a shared multiplier.
`timescale 1ns / 1ps

module bcc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bcc_pkg::cfg_t cfg_i,
  input  bcc_pkg::req_t req_i,
  input  logic          req_valid_i,
  output logic          req_pop_o,
  bcc_out_if.source     out_o
);
  import bcc_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_CORDIC, S_GYRO, S_LOWPASS, S_HIGHPASS, S_FUSE, S_ERROR, S_HIST,
    S_MAC, S_MAC_LAST, S_GAIN, S_CLAMP, S_ARM, S_DRIVE,
    S_ENC_L, S_ENC_R, S_ENC_DIFF, S_ENC_POS, S_ENC_REF, S_BUTTON, S_DONE
  } bstate_e;

  bstate_e            state_q, state_d;
  req_t               req_q, req_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [2:0]         mac_q, mac_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic signed [62:0] prod_q, prod_d;
  logic signed [55:0] acc_q, acc_d;
  logic signed [31:0] inc_q, inc_d, lp_q, lp_d, hp_q, hp_d, fused_q, fused_d;
  logic signed [31:0] err_q [3], err_d [3];
  logic signed [31:0] drv_q [3], drv_d [3];
  logic signed [31:0] ref_q [3], ref_d [3];
  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] wd_q, wd_d, pl_q, pl_d, pr_q, pr_d, u_q, u_d;
  logic               armed_q, armed_d;
  logic [15:0]        pick_q, pick_d, ovl_q, ovl_d;
  fault_e             fault_q, fault_d;
  logic               zero_q, zero_d, on_q, on_d;
  logic signed [15:0] ldrv_q, ldrv_d, rdrv_q, rdrv_d;
  out_item_t          res_q, res_d;
  logic               res_valid_q, res_valid_d;
  logic signed [38:0] mul_a;
  logic signed [23:0] mul_b;
  logic               mul_en;

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // Next state, datapath and multiplier operands
  always_comb begin
    logic signed [35:0] xi, yi, xs, ys;
    logic signed [31:0] k;
    logic signed [63:0] t, af, d0;
    logic [15:0]        pk1, oc;
    logic               clr, lie, arm_now, a1;

    state_d = state_q;  req_d = req_q;  cnt_d = cnt_q;  mac_d = mac_q;
    x_d = x_q;  y_d = y_q;  z_d = z_q;  acc_d = acc_q;
    inc_d = inc_q;  lp_d = lp_q;  hp_d = hp_q;  fused_d = fused_q;
    err_d = err_q;  drv_d = drv_q;  ref_d = ref_q;  pos_d = pos_q;
    wd_d = wd_q;  pl_d = pl_q;  pr_d = pr_q;  u_d = u_q;
    armed_d = armed_q;  pick_d = pick_q;  ovl_d = ovl_q;
    fault_d = fault_q;  zero_d = zero_q;  on_d = on_q;
    ldrv_d = ldrv_q;  rdrv_d = rdrv_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !out_o.ready;
    req_pop_o = 1'b0;
    mul_en = 1'b0;  mul_a = '0;  mul_b = '0;
    xi = '0;  yi = '0;  xs = '0;  ys = '0;  k = '0;  t = '0;  af = '0;  d0 = '0;
    pk1 = '0;  oc = '0;  clr = 1'b0;  lie = 1'b0;  arm_now = 1'b0;  a1 = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          req_d   = req_i;
          fault_d = FAULT_NONE;
          zero_d  = 1'b0;
          on_d    = 1'b0;
          ldrv_d  = '0;
          rdrv_d  = '0;
          // Set up the CORDIC vector: x = accel_y, y = -accel_z
          xi = 36'(req_i.accel_y) <<< 16;
          yi = (-36'(req_i.accel_z)) <<< 16;
          x_d = xi;  y_d = yi;  z_d = '0;  cnt_d = '0;
          if (xi < 0) begin
            z_d = (yi >= 0) ? 32'(PI_K) : -32'(PI_K);
            x_d = -xi;
            y_d = -yi;
          end
          unique case (req_i.kind)
            REQ_IMU: state_d = S_CORDIC;
            REQ_ENC: state_d = S_ENC_L;
            REQ_BTN: state_d = S_BUTTON;
            default: state_d = S_DONE;
          endcase
        end
      end

      // One CORDIC rotation per cycle
      S_CORDIC: begin
        xs = x_q >>> cnt_q;
        ys = y_q >>> cnt_q;
        k  = atan_k(5'(cnt_q));
        if (y_q > 0) begin
          x_d = x_q + ys;  y_d = y_q - xs;  z_d = z_q + k;
        end else if (y_q < 0) begin
          x_d = x_q - ys;  y_d = y_q + xs;  z_d = z_q - k;
        end
        if (cnt_q == CW'(CORDIC_STEPS - 1)) state_d = S_GYRO;
        else cnt_d = cnt_q + 1'b1;
      end

      S_GYRO: begin
        mul_en = 1'b1;
        mul_a = 39'(req_q.gyro);
        mul_b = 24'(GYRO_K);
        state_d = S_LOWPASS;
      end

      S_LOWPASS: begin
        t = 64'(prod_q) >>> Q30_SHIFT;
        inc_d = t[31:0];
        mul_en = 1'b1;
        mul_a = 39'(z_q) - 39'(lp_q);
        mul_b = 24'($signed({1'b0, cfg_i.filter_alpha}));
        state_d = S_HIGHPASS;
      end

      S_HIGHPASS: begin
        lp_d = sat32(64'(lp_q) + (64'(prod_q) >>> 16));
        mul_en = 1'b1;
        mul_a = 39'(hp_q);
        mul_b = 24'($signed({1'b0, cfg_i.filter_alpha}));
        state_d = S_FUSE;
      end

      S_FUSE: begin
        hp_d = sat32(64'(hp_q) - (64'(prod_q) >>> 16) + 64'(inc_q));
        state_d = S_ERROR;
      end

      S_ERROR: begin
        fused_d = sat32(64'(lp_q) + 64'(hp_q) + (64'(cfg_i.body_trim) <<< Q12_SHIFT));
        state_d = S_HIST;
      end

      S_HIST: begin
        err_d[2] = err_q[1];
        err_d[1] = err_q[0];
        err_d[0] = sat32(64'(ref_q[0]) - 64'(fused_q));
        mac_d = '0;
        acc_d = '0;
        state_d = S_MAC;
      end

      // Multiply-accumulate over five history taps
      S_MAC: begin
        mul_en = 1'b1;
        if (req_q.kind == REQ_IMU) begin
          case (mac_q)
            3'd0:    begin mul_a = 39'(drv_q[0]); mul_b = C_D0; end
            3'd1:    begin mul_a = 39'(drv_q[1]); mul_b = C_D1; end
            3'd2:    begin mul_a = 39'(err_q[0]); mul_b = C_E0; end
            3'd3:    begin mul_a = 39'(err_q[1]); mul_b = C_E1; end
            default: begin mul_a = 39'(err_q[2]); mul_b = C_E2; end
          endcase
        end else begin
          case (mac_q)
            3'd0:    begin mul_a = 39'(ref_q[0]); mul_b = C_R0; end
            3'd1:    begin mul_a = 39'(ref_q[1]); mul_b = C_R1; end
            3'd2:    begin mul_a = 39'(pos_q[0]); mul_b = C_P0; end
            3'd3:    begin mul_a = 39'(pos_q[1]); mul_b = C_P1; end
            default: begin mul_a = 39'(pos_q[2]); mul_b = C_P2; end
          endcase
        end
        if (mac_q != 3'd0) acc_d = acc_q + 56'(prod_q);
        if (mac_q == 3'(MAC_TERMS - 1)) state_d = S_MAC_LAST;
        else mac_d = mac_q + 1'b1;
      end

      S_MAC_LAST: begin
        acc_d = acc_q + 56'(prod_q);
        state_d = (req_q.kind == REQ_IMU) ? S_GAIN : S_ENC_REF;
      end

      S_GAIN: begin
        t = 64'(acc_q) >>> 16;
        mul_en = 1'b1;
        mul_a = t[38:0];
        mul_b = 24'($signed({1'b0, cfg_i.inner_gain}));
        state_d = S_CLAMP;
      end

      // Clamp the drive to +-1 and shift the drive history
      S_CLAMP: begin
        t = 64'(prod_q) >>> 14;
        if (t > ONE_K) t = ONE_K;
        if (t < -ONE_K) t = -ONE_K;
        drv_d[2] = drv_q[1];
        drv_d[1] = drv_q[0];
        drv_d[0] = t[31:0];
        state_d = req_q.sd ? S_DONE : S_ARM;
      end

      // Pickup arming, fall check and overload timer
      S_ARM: begin
        af  = (fused_q < 0) ? -64'(fused_q) : 64'(fused_q);
        lie = (64'(fused_q) > -LIE_HI_K) && (64'(fused_q) < -LIE_LO_K);
        pk1 = (lie && pick_q != 16'hffff) ? pick_q + 1'b1 : pick_q;
        arm_now = (af < $signed(64'(cfg_i.start_range) <<< Q12_SHIFT)) && !armed_q &&
                  (pk1 > 16'(cfg_i.pickup_limit));
        clr = arm_now;
        a1  = armed_q || arm_now;
        pick_d = arm_now ? 16'd0 : pk1;
        armed_d = a1;
        if (a1) begin
          if (af > $signed(64'(cfg_i.tip_limit) <<< Q12_SHIFT)) begin
            clr = 1'b1;
            armed_d = 1'b0;
            fault_d = FAULT_FELL;
          end
          d0 = clr ? 64'sd0 : 64'(drv_q[0]);
          if (((d0 < 0) ? -d0 : d0) > OVER_K) oc = (ovl_q != 16'hffff) ? ovl_q + 1'b1 : ovl_q;
          else oc = 16'd0;
          if (oc > 16'(cfg_i.overload_limit)) begin
            clr = 1'b1;
            armed_d = 1'b0;
            oc = 16'd0;
            fault_d = FAULT_STALL;
          end
          ovl_d = oc;
          u_d = clr ? 32'sd0 : drv_q[0];
          on_d = armed_d;
        end
        if (clr) begin
          zero_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            err_d[i] = '0;  drv_d[i] = '0;  ref_d[i] = '0;  pos_d[i] = '0;
          end
        end
        mul_en = 1'b1;
        mul_a = 39'(wd_q);
        mul_b = 24'($signed({1'b0, cfg_i.steer_k}));
        state_d = S_DRIVE;
      end

      // Apply steering and saturate wheel duties
      S_DRIVE: begin
        t = 64'(prod_q) >>> 12;
        if (on_q) begin
          ldrv_d = sat16((64'(u_q) - t) >>> Q15_SHIFT);
          rdrv_d = sat16((-(64'(u_q) + t)) >>> Q15_SHIFT);
        end
        state_d = S_DONE;
      end

      S_ENC_L: begin
        mul_en = 1'b1;
        mul_a = 39'(req_q.left);
        mul_b = 24'(WHEEL_K);
        state_d = S_ENC_R;
      end

      S_ENC_R: begin
        pl_d = sat32(64'(prod_q) >>> Q30_SHIFT);
        mul_en = 1'b1;
        mul_a = -39'(req_q.right);
        mul_b = 24'(WHEEL_K);
        state_d = S_ENC_DIFF;
      end

      S_ENC_DIFF: begin
        pr_d = sat32(64'(prod_q) >>> Q30_SHIFT);
        wd_d = sat32(64'(pl_q) - 64'(pr_d));
        state_d = S_ENC_POS;
      end

      S_ENC_POS: begin
        k = sat32(((64'(pl_q) + 64'(pr_q)) >>> 1) + 64'(fused_q));
        pos_d[2] = pos_q[1];
        pos_d[1] = pos_q[0];
        pos_d[0] = sat32(-64'(k));
        mac_d = '0;
        acc_d = '0;
        state_d = S_MAC;
      end

      S_ENC_REF: begin
        ref_d[2] = ref_q[1];
        ref_d[1] = ref_q[0];
        ref_d[0] = sat32(64'(acc_q) >>> 16);
        state_d = S_DONE;
      end

      // Toggle arming on a button request; arm only while the body angle is within the start range
      S_BUTTON: begin
        af = (fused_q < 0) ? -64'(fused_q) : 64'(fused_q);
        if (armed_q) begin
          clr = 1'b1;
          armed_d = 1'b0;
        end else if (af < $signed(64'(cfg_i.start_range) <<< Q12_SHIFT)) begin
          clr = 1'b1;
          armed_d = 1'b1;
        end
        if (clr) begin
          zero_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            err_d[i] = '0;  drv_d[i] = '0;  ref_d[i] = '0;  pos_d[i] = '0;
          end
        end
        state_d = S_DONE;
      end

      // Hold until the result register is free
      S_DONE: begin
        if (!res_valid_q || out_o.ready) begin
          res_d.left_drive     = ldrv_q;
          res_d.right_drive    = rdrv_q;
          res_d.motors_enabled = armed_q && !req_q.sd;
          res_d.armed          = armed_q;
          res_d.fault          = fault_q;
          res_d.zero_encoders  = zero_q;
          res_d.body_angle     = sat16(64'(fused_q) >>> Q12_SHIFT);
          res_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign prod_d = mul_en ? mul_a * mul_b : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      lp_q        <= '0;
      hp_q        <= '0;
      fused_q     <= '0;
      wd_q        <= '0;
      armed_q     <= 1'b0;
      pick_q      <= '0;
      ovl_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        err_q[i] <= '0;  drv_q[i] <= '0;  ref_q[i] <= '0;  pos_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      lp_q        <= lp_d;
      hp_q        <= hp_d;
      fused_q     <= fused_d;
      wd_q        <= wd_d;
      armed_q     <= armed_d;
      pick_q      <= pick_d;
      ovl_q       <= ovl_d;
      err_q       <= err_d;
      drv_q       <= drv_d;
      ref_q       <= ref_d;
      pos_q       <= pos_d;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cnt_q   <= cnt_d;
    mac_q   <= mac_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    inc_q   <= inc_d;
    pl_q    <= pl_d;
    pr_q    <= pr_d;
    u_q     <= u_d;
    fault_q <= fault_d;
    zero_q  <= zero_d;
    on_q    <= on_d;
    ldrv_q  <= ldrv_d;
    rdrv_q  <= rdrv_d;
    res_q   <= res_d;
  end

endmodule

// ===== sv/balance_cascade_controller.sv =====
// Top level of the balance cascade controller: configuration registers, front and back ends.
//
//   Channel   Dir  Handshake         Payload
//   in_i      in   valid/ready       mode, accel_y/z, gyro_rate, left/right_count, shutting_down
//   out_o     out  valid/ready       left/right_drive, motors_enabled, armed, fault,
//                                    zero_encoders, body_angle
//   cfg_*     in   write enable      cfg_idx_i selects register, cfg_data_i value
//
// IMU requests run one CORDIC rotation per cycle, then a sequence of steps on the
// single shared multiplier; while shutting down the arming and drive steps are skipped.
// A two-entry queue takes new requests while the back end works or its result waits.
// Reset clears the FSMs, queue pointers, config and loop state at once; no clearing pass.
`timescale 1ns / 1ps

module balance_cascade_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcc_in_if.sink      in_i,
  bcc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;
  req_t req;
  logic req_valid;
  logic req_pop;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BODY_TRIM:      cfg_d.body_trim      = $signed(cfg_data_i);
        CFG_START_RANGE:    cfg_d.start_range    = cfg_data_i[14:0];
        CFG_TIP_LIMIT:      cfg_d.tip_limit      = cfg_data_i[14:0];
        CFG_STEER_K:        cfg_d.steer_k        = cfg_data_i[14:0];
        CFG_OVERLOAD_LIMIT: cfg_d.overload_limit = cfg_data_i[9:0];
        CFG_PICKUP_LIMIT:   cfg_d.pickup_limit   = cfg_data_i[9:0];
        CFG_FILTER_ALPHA:   cfg_d.filter_alpha   = cfg_data_i;
        CFG_INNER_GAIN:     cfg_d.inner_gain     = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.body_trim      <= 16'sd1270;
      cfg_q.start_range    <= 15'd819;
      cfg_q.tip_limit      <= 15'd4915;
      cfg_q.steer_k        <= 15'd1024;
      cfg_q.overload_limit <= 10'd50;
      cfg_q.pickup_limit   <= 10'd200;
      cfg_q.filter_alpha   <= 16'd328;
      cfg_q.inner_gain     <= 16'd16466;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop)
  );

  bcc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .out_o       (out_o)
  );

  // Wheels are driven only while armed and enabled
  a_drive_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.left_drive != 16'sd0 || out_o.data.right_drive != 16'sd0)
    |-> out_o.data.armed && out_o.data.motors_enabled)
    else $error("wheel drive while disarmed");

  // A fault disarms and asks for an encoder reset
  a_fault_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.fault != FAULT_NONE
    |-> !out_o.data.armed && out_o.data.zero_encoders)
    else $error("fault without disarm");

  // Motors are enabled only when armed
  a_enable_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.motors_enabled |-> out_o.data.armed)
    else $error("motors enabled while disarmed");

endmodule
